/* hdl/slfr_pkg.sv */
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared types and constants of the sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 17;
  localparam int unsigned LenW    = 16;
  localparam int unsigned StageW  = 2;
  localparam int unsigned RegIdxW = 1;

  // Result word layout, lowest bit first.
  localparam int unsigned ResultBits = CountW + ByteW + StageW + 1 + LenW;
  localparam int unsigned ResultW    = ((ResultBits + 7) / 8) * 8;

  localparam int unsigned QueueDepth = 2;

  // Register indexes of the configuration port.
  localparam logic [RegIdxW-1:0] REG_SYNC_FIRST  = 1'b0;
  localparam logic [RegIdxW-1:0] REG_SYNC_SECOND = 1'b1;

  localparam logic [ByteW-1:0] SyncFirstReset  = 8'hEF;
  localparam logic [ByteW-1:0] SyncSecondReset = 8'h01;

  // Receiver stages.
  localparam logic [StageW-1:0] STAGE_HUNT  = 2'd0;
  localparam logic [StageW-1:0] STAGE_SYNC1 = 2'd1;
  localparam logic [StageW-1:0] STAGE_BODY  = 2'd2;

  // Frame byte positions of the big-endian length.
  localparam logic [CountW-1:0] LenHiIndex = 17'd7;
  localparam logic [CountW-1:0] LenLoIndex = 17'd8;

  // One classified byte, as passed from the front end to the back end.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             hit_first;
    logic             hit_second;
  } slfr_entry_t;

endpackage

/* hdl/slfr_front.sv */
// ----------------------------------------------------------------------------
// slfr_front
// Holds the sync byte registers and tags each incoming byte with its matches.
// ----------------------------------------------------------------------------
module slfr_front
  import slfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  input  logic [ByteW-1:0]   in_data_i,
  output logic               in_ready_o,
  output logic               push_o,
  output slfr_entry_t        entry_o,
  input  logic               queue_ready_i
);

  logic [ByteW-1:0] sync_first_q, sync_first_d;
  logic [ByteW-1:0] sync_second_q, sync_second_d;

  always_comb begin
    sync_first_d  = sync_first_q;
    sync_second_d = sync_second_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SYNC_FIRST:  sync_first_d  = cfg_data_i;
        REG_SYNC_SECOND: sync_second_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstReset;
      sync_second_q <= SyncSecondReset;
    end else begin
      sync_first_q  <= sync_first_d;
      sync_second_q <= sync_second_d;
    end
  end

  // Both comparisons are done here so the back end only selects by stage.
  assign in_ready_o          = queue_ready_i;
  assign push_o              = in_valid_i && queue_ready_i;
  assign entry_o.data        = in_data_i;
  assign entry_o.hit_first   = (in_data_i == sync_first_q);
  assign entry_o.hit_second  = (in_data_i == sync_second_q);

endmodule

/* hdl/slfr_queue.sv */
// ----------------------------------------------------------------------------
// slfr_queue
// Short first-in first-out queue of classified bytes.
// ----------------------------------------------------------------------------
module slfr_queue
  import slfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  slfr_entry_t push_entry_i,
  output logic        ready_o,
  input  logic        pop_i,
  output logic        valid_o,
  output slfr_entry_t head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  slfr_entry_t           mem_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       fill_q, fill_d;
  logic                  do_pop;

  assign ready_o = (fill_q != CntW'(QueueDepth));
  assign valid_o = (fill_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* hdl/slfr_back.sv */
// ----------------------------------------------------------------------------
// slfr_back
// Frame state machine and result register.
// ----------------------------------------------------------------------------
module slfr_back
  import slfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  slfr_entry_t        head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output logic [ResultW-1:0] out_data_o,
  input  logic               out_ready_i
);

  logic [StageW-1:0]  stage_q, stage_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [ByteW-1:0]   len_hi_q, len_hi_d;
  logic [LenW-1:0]    len_q, len_d;
  logic               done_q, done_d;
  logic               out_valid_q, out_valid_d;
  logic [ResultW-1:0] out_data_q, out_data_d;

  logic [CountW-1:0]  next_cnt;
  logic [LenW-1:0]    body_len;
  logic [CountW-1:0]  end_limit;

  assign pop_o     = head_valid_i && (!out_valid_q || out_ready_i);
  assign next_cnt  = count_q + 1'b1;
  assign body_len  = (count_q == LenLoIndex) ? {len_hi_q, head_i.data} : len_q;
  assign end_limit = {1'b0, body_len} + LenLoIndex;

  always_comb begin
    stage_d  = stage_q;
    count_d  = count_q;
    len_hi_d = len_hi_q;
    len_d    = len_q;
    done_d   = done_q;
    if (pop_o) begin
      unique case (stage_q)
        STAGE_HUNT: begin
          stage_d = head_i.hit_first ? STAGE_SYNC1 : STAGE_HUNT;
          count_d = head_i.hit_first ? next_cnt : '0;
        end
        STAGE_SYNC1: begin
          stage_d = head_i.hit_second ? STAGE_BODY : STAGE_HUNT;
          count_d = head_i.hit_second ? next_cnt : '0;
        end
        default: begin
          // In frame; the unused code behaves the same way.
          count_d = next_cnt;
          if (count_q == LenHiIndex) begin
            len_hi_d = head_i.data;
          end
          if (next_cnt > LenLoIndex) begin
            len_d = body_len;
            if (next_cnt > end_limit) begin
              count_d = '0;
              stage_d = STAGE_HUNT;
              done_d  = 1'b1;
            end else begin
              done_d = 1'b0;
            end
          end else begin
            len_d = '0;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      out_data_d  = ResultW'({len_d, done_d, stage_d, head_i.data, count_q});
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= STAGE_HUNT;
      count_q     <= '0;
      len_hi_q    <= '0;
      len_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stage_q     <= stage_d;
      count_q     <= count_d;
      len_hi_q    <= len_hi_d;
      len_q       <= len_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* hdl/sync_length_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Two-byte sync, length-prefixed byte stream deframer.
// ----------------------------------------------------------------------------
// The receiver takes one byte per request and returns one result per byte,
// each byte passing through the queue and the output register, and it
// sustains one byte per clock cycle while the output takes results. It hunts
// for the first sync byte, then expects the second one, then counts body
// bytes; frame bytes 7 and 8 (the first sync byte being byte 0) give a
// big-endian length L, and the frame ends on the byte with index 8 + L. Each
// result carries the byte's index in the frame, the byte, the stage after it,
// the done flag and the declared length. A byte that fails a sync check sends
// the block back to hunting and is not tried again as a first sync byte. The
// sync values are written through the configuration port; the user must do so
// only while no traffic is in flight, as the block itself does not enforce it.
//
// Inside, a front end compares each byte against both sync values, a
// two-entry queue holds the tagged bytes, and a back end runs the frame state
// machine and drives a registered output. The rate is set by that state
// machine, which handles one byte per cycle while results are taken; a spare
// queue entry absorbs an output stall before the input side sees backpressure.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver
  import slfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  // Byte input.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ByteW-1:0]   s_axis_tdata,   // rx_byte[7:0]
  // Result output.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // From bit 0: byte_index[16:0], stored_byte[24:17], stage[26:25],
  // frame_done[27], declared_length[43:28], zero fill[47:44].
  output logic [ResultW-1:0] m_axis_tdata
);

  logic        push;
  logic        queue_ready;
  slfr_entry_t push_entry;
  logic        head_valid;
  slfr_entry_t head;
  logic        pop;

  slfr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_data_i     (s_axis_tdata),
    .in_ready_o    (s_axis_tready),
    .push_o        (push),
    .entry_o       (push_entry),
    .queue_ready_i (queue_ready)
  );

  slfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (queue_ready),
    .pop_i        (pop),
    .valid_o      (head_valid),
    .head_o       (head)
  );

  slfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata),
    .out_ready_i  (m_axis_tready)
  );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-byte sync, length-prefixed frame receiver.
// ----------------------------------------------------------------------------
// Bytes go into the receiver as stream requests. A deframer model inside the
// bench follows every accepted byte and queues the result it should produce.
// A checker pops that queue for each result request and compares it field by
// field. The run has directed sequences first: the reset sync values, the
// done flag holding and clearing, and wrong sync bytes. One long frame with
// both length bytes nonzero follows. Then several sync settings are tried,
// among them the extremes and equal values. Last comes random traffic of
// mostly well-formed frames under four mixes of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module testbench;
  import slfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run limits. Every byte gives exactly one result, so a short tail is enough
  // once the queue has drained.
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainLimit = 4000;
  localparam int unsigned DrainTail  = 6;
  localparam int unsigned MaxReports = 20;
  localparam int unsigned PhaseItems = 340;

  // Result word as it leaves the block, lowest field in the lowest bits.
  typedef struct packed {
    logic [ResultW-ResultBits-1:0] fill;
    logic [LenW-1:0]               declared_length;
    logic                          frame_done;
    logic [StageW-1:0]             stage;
    logic [ByteW-1:0]              stored_byte;
    logic [CountW-1:0]             byte_index;
  } frame_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i     = REG_SYNC_FIRST;
  logic [ByteW-1:0]   cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ResultW-1:0] m_axis_tdata;

  sync_length_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Deframer model. Its state starts at the reset values and is only ever
  // advanced by accepted byte requests and register writes.
  // --------------------------------------------------------------------------
  logic [ByteW-1:0]  mdl_first  = SyncFirstReset;
  logic [ByteW-1:0]  mdl_second = SyncSecondReset;
  logic [StageW-1:0] mdl_stage  = STAGE_HUNT;
  logic [CountW-1:0] mdl_count  = '0;
  logic [ByteW-1:0]  mdl_len_hi = '0;
  logic [LenW-1:0]   mdl_length = '0;
  logic              mdl_done   = 1'b0;

  frame_result_t pending_results[$];

  int unsigned bytes_taken     = 0;
  int unsigned results_checked = 0;
  int unsigned frames_done     = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;
  int unsigned settings_used   = 1;

  // Moves the model by one received byte and returns the result it implies.
  function automatic frame_result_t advance_deframer(logic [ByteW-1:0] rx);
    frame_result_t     res;
    logic [CountW-1:0] idx;
    logic [CountW-1:0] nxt;
    idx = mdl_count;
    nxt = idx + 1'b1;
    // The high stage bit decides first, so an in-frame byte never sees the
    // sync compares.
    if (mdl_stage[1]) begin
      if (idx == LenHiIndex) begin
        mdl_len_hi = rx;
      end
      if (nxt > LenLoIndex) begin
        if (idx == LenLoIndex) begin
          mdl_length = {mdl_len_hi, rx};
        end
        if (nxt > LenLoIndex + CountW'(mdl_length)) begin
          nxt         = '0;
          mdl_stage   = STAGE_HUNT;
          mdl_done    = 1'b1;
          frames_done = frames_done + 1;
        end else begin
          mdl_done = 1'b0;
        end
      end else begin
        // The length only counts once its low byte has arrived.
        mdl_length = '0;
      end
      mdl_count = nxt;
    end else if (mdl_stage[0]) begin
      if (rx == mdl_second) begin
        mdl_count = nxt;
        mdl_stage = STAGE_BODY;
      end else begin
        mdl_count = '0;
        mdl_stage = STAGE_HUNT;
      end
    end else begin
      if (rx == mdl_first) begin
        mdl_count = nxt;
        mdl_stage = STAGE_SYNC1;
      end else begin
        mdl_count = '0;
        mdl_stage = STAGE_HUNT;
      end
    end
    res.fill            = '0;
    res.byte_index      = idx;
    res.stored_byte     = rx;
    res.stage           = mdl_stage;
    res.frame_done      = mdl_done;
    res.declared_length = mdl_length;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [CountW-1:0] want_v,
                             input logic [CountW-1:0] got_v);
    if (want_v !== got_v) begin
      error_count = error_count + 1;
      if (error_count <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      end
    end
  endtask

  // Both handshakes and the register port are sampled at the rising edge,
  // before any of this edge's nonblocking updates land. A result always passes
  // through the receiver's queue and output register behind its byte, so pushing
  // and popping in the same pass cannot pair the wrong entries.
  always @(posedge clk_i) begin
    frame_result_t want;
    frame_result_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SYNC_FIRST) begin
          mdl_first = cfg_data_i;
        end else begin
          mdl_second = cfg_data_i;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(advance_deframer(s_axis_tdata));
        bytes_taken = bytes_taken + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_results.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= MaxReports) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
          end
        end else begin
          want = pending_results.pop_front();
          results_checked = results_checked + 1;
          check_field("byte_index", want.byte_index, got.byte_index);
          check_field("stored_byte", CountW'(want.stored_byte), CountW'(got.stored_byte));
          check_field("stage", CountW'(want.stage), CountW'(got.stage));
          check_field("frame_done", CountW'(want.frame_done), CountW'(got.frame_done));
          check_field("declared_length", CountW'(want.declared_length),
                      CountW'(got.declared_length));
          check_field("zero fill", CountW'(want.fill), CountW'(got.fill));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still awaited",
               cycle_count, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. The sender skips a cycle with probability idle_pct, the
  // receiver drops tready with probability stall_pct, both in percent.
  // --------------------------------------------------------------------------
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Sync values as last written, used to build frames.
  logic [ByteW-1:0] tx_first  = SyncFirstReset;
  logic [ByteW-1:0] tx_second = SyncSecondReset;

  task automatic set_pressure(input int unsigned sender, input int unsigned receiver);
    idle_pct  = sender;
    stall_pct = receiver;
  endtask

  // Sends one byte request. On return the request has just been accepted at
  // this edge and tvalid is still high, so the next call or settle() makes
  // the only assignment to it in this time step.
  task automatic send_byte(input logic [ByteW-1:0] rx);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
  endtask

  // A well-formed frame: two sync bytes, five header bytes, the big-endian
  // length and then exactly that many body bytes.
  task automatic send_frame(input logic [LenW-1:0] len);
    int unsigned k;
    send_byte(tx_first);
    send_byte(tx_second);
    repeat (5) send_byte(ByteW'($urandom_range(255)));
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (k = 0; k < len; k++) begin
      send_byte(ByteW'($urandom_range(255)));
    end
  endtask

  // Stops sending and waits until every queued result has come out, or until DrainLimit is reached.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited = waited + 1;
    end
    repeat (DrainTail) @(posedge clk_i);
  endtask

  // Writes both sync registers back to back while the block is idle.
  task automatic write_syncs(input logic [ByteW-1:0] first, input logic [ByteW-1:0] second);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SYNC_FIRST;
    cfg_data_i <= first;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SYNC_SECOND;
    cfg_data_i <= second;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    tx_first  = first;
    tx_second = second;
    settings_used = settings_used + 1;
  endtask

  function automatic logic [LenW-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      return LenW'($urandom_range(24));
    end else if (r < 95) begin
      return LenW'($urandom_range(200, 25));
    end
    return LenW'($urandom_range(700, 256));
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset sync values. A zero-length frame ends on its low length byte and
  // sets the done flag. The flag then holds through two hunting bytes, the sync
  // bytes and the header. The low length byte of the next frame clears it,
  // and that frame's end sets it again.
  task automatic test_done_flag();
    set_pressure(0, 0);
    send_frame(16'h0000);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(16'h0002);
    settle();
  endtask

  // Wrong sync bytes. A wrong second sync byte drops back to hunting, and that
  // byte is not tried as a first sync byte, even when it equals one.
  task automatic test_bad_sync();
    set_pressure(0, 0);
    send_byte(8'h33);
    send_byte(tx_first);
    send_byte(8'h33);
    send_byte(tx_first);
    send_byte(tx_first);
    send_byte(tx_second);
    send_byte(tx_first);
    send_byte(8'hFF);
    send_byte(tx_second);
    settle();
  endtask

  // A long frame with both length bytes nonzero carries the byte index
  // well past one byte.
  task automatic test_long_frame();
    set_pressure(0, 0);
    send_frame(16'h012C);
    settle();
  endtask

  // Extreme, equal and random sync values, each with two frames around a broken
  // start. The old default first sync byte is sent as plain noise.
  task automatic test_sync_settings();
    logic [ByteW-1:0] firsts[4];
    logic [ByteW-1:0] seconds[4];
    int unsigned      s;
    firsts  = '{8'h00, 8'hFF, 8'h5A, ByteW'($urandom_range(255))};
    seconds = '{8'hFF, 8'h00, 8'h5A, ByteW'($urandom_range(255))};
    set_pressure(20, 20);
    for (s = 0; s < 4; s++) begin
      write_syncs(firsts[s], seconds[s]);
      send_byte(SyncFirstReset);
      send_frame(LenW'($urandom_range(3)));
      send_byte(tx_first);
      send_byte(~tx_second);
      send_frame(LenW'($urandom_range(12, 4)));
    end
    settle();
  endtask

  // Random traffic: mostly well-formed frames, some broken sync sequences and
  // some noise, under four pressure mixes with a new sync setting each time.
  task automatic test_random_traffic();
    int unsigned      senders[4];
    int unsigned      receivers[4];
    int unsigned      p;
    int unsigned      shaped;
    int unsigned      mark;
    int unsigned      choice;
    logic [ByteW-1:0] wrong;
    senders   = '{0, 50, 0, 34};
    receivers = '{0, 0, 50, 34};
    for (p = 0; p < 4; p++) begin
      if (p == 0) begin
        write_syncs(SyncFirstReset, SyncSecondReset);
      end else begin
        write_syncs(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)));
      end
      set_pressure(senders[p], receivers[p]);
      shaped = 0;
      while (shaped < PhaseItems) begin
        mark   = bytes_taken;
        choice = $urandom_range(99);
        if (choice < 75) begin
          send_frame(pick_length());
          shaped = shaped + (bytes_taken - mark);
        end else if (choice < 87) begin
          // Broken starts. A differing byte after the first sync, a repeated
          // first sync, or a lone first sync followed by whatever comes next.
          wrong = tx_second ^ ByteW'($urandom_range(255, 1));
          case ($urandom_range(2))
            0: begin
              send_byte(tx_first);
              send_byte(wrong);
            end
            1: begin
              send_byte(tx_first);
              send_byte(tx_first);
              send_byte(tx_second);
            end
            default: begin
              send_byte(tx_first);
            end
          endcase
          shaped = shaped + (bytes_taken - mark);
        end else begin
          repeat ($urandom_range(4, 1)) send_byte(ByteW'($urandom_range(255)));
        end
      end
      // The last request has been taken by now, so the counts above are exact.
      settle();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_done_flag();
    test_bad_sync();
    test_long_frame();
    test_sync_settings();
    test_random_traffic();
    settle();
    repeat (DrainTail) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      error_count = error_count + 1;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("Run covered %0d bytes, %0d results compared, %0d frames completed,",
             bytes_taken, results_checked, frames_done);
    $display("over %0d sync settings and four sender/receiver pressure mixes; %0d errors.",
             settings_used, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
